// ===== hdl/fmv_pkg.sv =====
package fmv_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int SINE_TABLE_BITS = 10;
  localparam int OUT_BITS        = 16;
  localparam longint SAMPLE_RATE_HZ = 44100;

  localparam int QUARTER    = 1 << (SINE_TABLE_BITS - 2);
  localparam int NOTE_COUNT = 128;
  localparam int NOTE_W     = 7;
  localparam int KIND_W     = 2;
  localparam int OSC_COUNT  = 4;
  localparam int OSC_IDX_W  = 2;
  localparam int LEVEL_W    = 15;
  localparam int DEPTH_W    = 16;
  localparam int DETUNE_W   = 28;
  localparam int GAIN_W     = 16;
  localparam int SINE_W     = 16;
  localparam int PROD_W     = DEPTH_W + 1 + SINE_W;
  localparam int ACC_W      = 34;
  localparam int GPROD_W    = ACC_W + GAIN_W + 1;
  localparam int MIX_SHIFT  = 46 - OUT_BITS;
  localparam int Y_W        = GPROD_W - MIX_SHIFT;
  localparam int OFF_UP     = (PHASE_BITS >= 31) ? PHASE_BITS - 31 : 0;
  localparam int OFF_DN     = (PHASE_BITS < 31) ? 31 - PHASE_BITS : 0;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 5;
  localparam int REG_IDX_W  = 3;

  localparam logic [GAIN_W-1:0] RESET_GAIN   = GAIN_W'(32767);
  localparam logic [GAIN_W-1:0] NOTE_ON_GAIN = GAIN_W'(3277);
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK     = 2'd0,
    KIND_NOTE_ON  = 2'd1,
    KIND_NOTE_OFF = 2'd2
  } kind_e;

  localparam logic [REG_IDX_W-1:0] REG_CARRIER_LEVEL = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SECOND_LEVEL  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_THIRD_LEVEL   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FOURTH_LEVEL  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MOD_DEPTH     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SECOND_DETUNE = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_THIRD_DETUNE  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_FOURTH_DETUNE = 3'd7;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_PH0,
    ST_MOD,
    ST_CAR,
    ST_MAC,
    ST_DET,
    ST_GAIN,
    ST_OUT
  } state_e;

  typedef logic [PHASE_BITS-1:0]    phase_t;
  typedef logic signed [SINE_W-1:0] sine_t;
  typedef logic [LEVEL_W-1:0]       sine_rom_t [QUARTER+1];
  typedef phase_t                   note_rom_t [NOTE_COUNT];

  localparam logic [63:0] OCT9_UHZ [12] = '{
    64'd8372018090,  64'd8869844190,  64'd9397272573,  64'd9956063479,
    64'd10548081821, 64'd11175303406, 64'd11839821527, 64'd12543853951,
    64'd13289750323, 64'd14080000000, 64'd14917240369, 64'd15804265640
  };

  localparam logic [63:0] TAYLOR_DIV [5] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110};

  // round(num * 2^bits / den) by long division, elaboration only
  function automatic logic [127:0] ratio_round(logic [63:0] num, logic [63:0] den, int bits);
    logic [127:0] dv;
    logic [127:0] q;
    logic [64:0]  r;
    int i;
    dv = {64'd0, num} << bits;
    q  = '0;
    r  = '0;
    for (i = 127; i >= 0; i--) begin
      r = {r[63:0], dv[i]};
      q = q << 1;
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[0] = 1'b1;
      end
    end
    r = r << 1;
    if (r >= {1'b0, den}) begin
      q = q + 128'd1;
    end
    return q;
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint sum;
    longint v;
    int i;
    int k;
    for (i = 0; i <= QUARTER; i++) begin
      x    = (PI_HALF_Q30 * 64'(i)) >> (SINE_TABLE_BITS - 2);
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (k = 1; k <= 5; k++) begin
        term = (term * x2) >> 30;
        term = term / TAYLOR_DIV[k-1];
        if ((k & 1) != 0) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = longint'((64'(sum) * 64'd32767 + 64'd536870912) >> 30);
      if (v > 32767) begin
        v = 32767;
      end
      rom[i] = v[LEVEL_W-1:0];
    end
    return rom;
  endfunction

  function automatic note_rom_t build_note_rom();
    note_rom_t rom;
    logic [63:0]  den;
    logic [127:0] q;
    int oct;
    int s;
    int n;
    rom = '{default: '0};
    for (oct = 0; oct <= 10; oct++) begin
      for (s = 0; s < 12; s++) begin
        n = oct * 12 + s;
        if (n < NOTE_COUNT) begin
          den    = (64'(SAMPLE_RATE_HZ) * 64'd1000000) << (10 - oct);
          q      = ratio_round(OCT9_UHZ[s], den, PHASE_BITS);
          rom[n] = q[PHASE_BITS-1:0];
        end
      end
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();
  localparam note_rom_t NOTE_ROM = build_note_rom();

  localparam logic [127:0] CARRIER_RESET_WIDE = ratio_round(64'd1, PI_HALF_Q30, PHASE_BITS + 28);
  localparam phase_t CARRIER_PHASE_RESET = CARRIER_RESET_WIDE[PHASE_BITS-1:0];

  // quarter-wave lookup: odd quadrants mirror, upper half negates
  function automatic sine_t sine_of(phase_t ph);
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [SINE_TABLE_BITS-3:0] pos;
    logic [SINE_TABLE_BITS-2:0] addr;
    sine_t v;
    idx  = ph[PHASE_BITS-1 -: SINE_TABLE_BITS];
    pos  = idx[SINE_TABLE_BITS-3:0];
    addr = idx[SINE_TABLE_BITS-2] ? (SINE_TABLE_BITS-1)'(QUARTER) - {1'b0, pos} : {1'b0, pos};
    v    = SINE_W'(SINE_ROM[addr]);
    return idx[SINE_TABLE_BITS-1] ? -v : v;
  endfunction

endpackage

// ===== hdl/fmv_ram.sv =====
module fmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hdl/fm_detuned_oscillator_voice.sv =====
// Monophonic phase-modulation voice: a self-modulated carrier plus three detuned
// sine oscillators, mixed and scaled by the voice gain.
// Input channel (in_valid_i/in_ready_o) carries kind_i and note_i. A note-on beat
// loads the carrier increment from the note table and sets the gain to 0.1; a
// note-off beat sets the gain to zero. Neither gives a result.
// A tick beat gives one sample_o beat on the output channel (out_valid_o/out_ready_i).
// A tick walks the four phases held in a 4-entry phase RAM one at a time. States
// PH0, MOD and CAR form the self-modulated carrier, MAC and DET then alternate with
// one multiply-accumulate per oscillator, GAIN scales the sum and OUT loads the sample
// into the output register; the next beat is taken only back in IDLE.
// The output register holds a finished sample while the receiver stalls; note
// beats are still taken, and a later tick waits in its last step until the
// register is free.
// After reset an init pass writes the initial phases into the RAM (carrier one
// radian, the others zero) with in_ready_o low; the APB port works throughout.
// Configuration registers live at byte address 4*index and are read back as
// written, detunes sign-extended.
module fm_detuned_oscillator_voice (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  output logic                                      in_ready_o,
  input  logic [fmv_pkg::KIND_W-1:0]                kind_i,
  input  logic [fmv_pkg::NOTE_W-1:0]                note_i,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output logic signed [fmv_pkg::OUT_BITS-1:0]       sample_o,
  input  logic                                      psel,
  input  logic                                      penable,
  input  logic                                      pwrite,
  input  logic [fmv_pkg::ADDR_W-1:0]                paddr,
  input  logic [fmv_pkg::DATA_W-1:0]                pwdata,
  output logic [fmv_pkg::DATA_W-1:0]                prdata,
  output logic                                      pready
);
  import fmv_pkg::*;

  state_e state_q, state_d;
  logic [OSC_IDX_W-1:0] init_cnt_q, init_cnt_d;
  logic [OSC_IDX_W-1:0] osc_q, osc_d;
  phase_t inc_q, inc_d;
  logic [GAIN_W-1:0] gain_q, gain_d;

  phase_t ph_q, ph_d;
  sine_t sin_q, sin_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [GPROD_W-1:0] gprod_q, gprod_d;
  logic signed [OUT_BITS-1:0] sample_q;
  logic out_valid_q;
  logic load;

  logic [LEVEL_W-1:0] level_q [OSC_COUNT];
  logic [DEPTH_W-1:0] mod_depth_q;
  logic signed [DETUNE_W-1:0] detune_q [OSC_COUNT-1];

  logic we;
  logic [OSC_IDX_W-1:0] waddr, raddr;
  phase_t wdata, rdata;

  logic [REG_IDX_W-1:0] reg_idx;
  logic cfg_we;

  logic signed [PHASE_BITS+PROD_W-1:0] off_wide;
  phase_t offset;
  logic signed [DETUNE_W-1:0] det_sel;
  phase_t det_ext;
  logic signed [2*SINE_W-1:0] mac_prod;
  logic signed [GPROD_W-1:0] rnd;
  logic signed [Y_W-1:0] y;
  logic [Y_W-OUT_BITS:0] y_top;
  logic signed [OUT_BITS-1:0] sat;

  fmv_ram #(
    .WIDTH(PHASE_BITS),
    .DEPTH(OSC_COUNT)
  ) u_phase_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_we  = psel & penable & pwrite;

  always_comb begin
    unique case (reg_idx)
      REG_CARRIER_LEVEL: prdata = DATA_W'(level_q[0]);
      REG_SECOND_LEVEL:  prdata = DATA_W'(level_q[1]);
      REG_THIRD_LEVEL:   prdata = DATA_W'(level_q[2]);
      REG_FOURTH_LEVEL:  prdata = DATA_W'(level_q[3]);
      REG_MOD_DEPTH:     prdata = DATA_W'(mod_depth_q);
      REG_SECOND_DETUNE: prdata = DATA_W'(detune_q[0]);
      REG_THIRD_DETUNE:  prdata = DATA_W'(detune_q[1]);
      REG_FOURTH_DETUNE: prdata = DATA_W'(detune_q[2]);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= '{default: '0};
      mod_depth_q <= '0;
      detune_q    <= '{default: '0};
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_CARRIER_LEVEL: level_q[0]  <= pwdata[LEVEL_W-1:0];
        REG_SECOND_LEVEL:  level_q[1]  <= pwdata[LEVEL_W-1:0];
        REG_THIRD_LEVEL:   level_q[2]  <= pwdata[LEVEL_W-1:0];
        REG_FOURTH_LEVEL:  level_q[3]  <= pwdata[LEVEL_W-1:0];
        REG_MOD_DEPTH:     mod_depth_q <= pwdata[DEPTH_W-1:0];
        REG_SECOND_DETUNE: detune_q[0] <= pwdata[DETUNE_W-1:0];
        REG_THIRD_DETUNE:  detune_q[1] <= pwdata[DETUNE_W-1:0];
        REG_FOURTH_DETUNE: detune_q[2] <= pwdata[DETUNE_W-1:0];
        default: ;
      endcase
    end
  end

  // phase offset of the carrier from its own sine
  assign off_wide = (PHASE_BITS+PROD_W)'(prod_q);
  always_comb begin
    logic signed [PHASE_BITS+PROD_W-1:0] sh;
    sh     = (off_wide <<< OFF_UP) >>> OFF_DN;
    offset = sh[PHASE_BITS-1:0];
  end

  // detune for the oscillator being read this step
  always_comb begin
    unique case (osc_q)
      2'd0:    det_sel = detune_q[0];
      2'd1:    det_sel = detune_q[1];
      2'd2:    det_sel = detune_q[2];
      default: det_sel = '0;
    endcase
  end
  assign det_ext = PHASE_BITS'((PHASE_BITS+DETUNE_W)'(det_sel));

  // level times sine of the oscillator in the accumulate step
  assign mac_prod = $signed({1'b0, level_q[osc_q]}) * sin_q;

  // round half up, then clamp to the output range
  assign rnd   = gprod_q + (GPROD_W'(1) <<< (MIX_SHIFT - 1));
  assign y     = rnd[GPROD_W-1:MIX_SHIFT];
  assign y_top = y[Y_W-1:OUT_BITS-1];
  assign sat   = ((&y_top) || !(|y_top)) ? y[OUT_BITS-1:0]
                                         : {y[Y_W-1], {(OUT_BITS-1){~y[Y_W-1]}}};

  always_comb begin
    state_d    = state_q;
    init_cnt_d = init_cnt_q;
    osc_d      = osc_q;
    inc_d      = inc_q;
    gain_d     = gain_q;
    ph_d       = ph_q;
    sin_d      = sin_q;
    prod_d     = prod_q;
    acc_d      = acc_q;
    gprod_d    = gprod_q;
    load       = 1'b0;
    we         = 1'b0;
    waddr      = osc_q + OSC_IDX_W'(1);
    wdata      = rdata + inc_q + det_ext;
    raddr      = osc_q + OSC_IDX_W'(1);
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        we         = 1'b1;
        waddr      = init_cnt_q;
        wdata      = (init_cnt_q == '0) ? CARRIER_PHASE_RESET : '0;
        init_cnt_d = init_cnt_q + OSC_IDX_W'(1);
        if (init_cnt_q == OSC_IDX_W'(OSC_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        raddr      = '0;
        if (in_valid_i) begin
          // the unused kind is taken and dropped
          unique case (kind_i)
            KIND_TICK: state_d = ST_PH0;
            KIND_NOTE_ON: begin
              inc_d  = NOTE_ROM[note_i];
              gain_d = NOTE_ON_GAIN;
            end
            KIND_NOTE_OFF: gain_d = '0;
            default: ;
          endcase
        end
      end
      ST_PH0: begin
        ph_d    = rdata;
        sin_d   = sine_of(rdata);
        we      = 1'b1;
        waddr   = '0;
        wdata   = rdata + inc_q;
        state_d = ST_MOD;
      end
      ST_MOD: begin
        prod_d  = $signed({1'b0, mod_depth_q}) * sin_q;
        state_d = ST_CAR;
      end
      ST_CAR: begin
        sin_d   = sine_of(ph_q + offset);
        acc_d   = '0;
        osc_d   = '0;
        state_d = ST_MAC;
      end
      ST_MAC: begin
        acc_d = acc_q + ACC_W'(mac_prod);
        if (osc_q == OSC_IDX_W'(OSC_COUNT - 1)) begin
          state_d = ST_GAIN;
        end else begin
          state_d = ST_DET;
        end
      end
      ST_DET: begin
        // rdata is the old phase of oscillator osc_q+1
        sin_d   = sine_of(rdata);
        we      = 1'b1;
        osc_d   = osc_q + OSC_IDX_W'(1);
        state_d = ST_MAC;
      end
      ST_GAIN: begin
        gprod_d = acc_q * $signed({1'b0, gain_q});
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      init_cnt_q  <= '0;
      osc_q       <= '0;
      inc_q       <= '0;
      gain_q      <= RESET_GAIN;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      init_cnt_q <= init_cnt_d;
      osc_q      <= osc_d;
      inc_q      <= inc_d;
      gain_q     <= gain_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ph_q    <= ph_d;
    sin_q   <= sin_d;
    prod_q  <= prod_d;
    acc_q   <= acc_d;
    gprod_q <= gprod_d;
    if (load) begin
      sample_q <= sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

endmodule

// ===== hdl/fmv_checker.sv =====
module fmv_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_o,
  input  logic [fmv_pkg::KIND_W-1:0]          kind_i,
  input  logic                                out_valid_o,
  input  logic                                out_ready_i,
  input  logic signed [fmv_pkg::OUT_BITS-1:0] sample_o,
  input  logic                                pready
);
  import fmv_pkg::*;

  // a tick keeps the input side closed while it is worked on
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && kind_i == KIND_TICK |=> !in_ready_o)
    else $error("input taken in the cycle after a tick");

  // note beats never create a sample
  a_note_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && kind_i != KIND_TICK && !out_valid_o |=> !out_valid_o)
    else $error("sample appeared after a note beat");

  // a sample only appears at the end of tick processing
  a_rise_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("sample appeared while idle");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_o))
    else $error("stalled sample changed or dropped");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind fm_detuned_oscillator_voice fmv_checker u_fmv_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .kind_i     (kind_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .sample_o   (sample_o),
  .pready     (pready)
);
